[sv/cip_pkg.sv]
// Package for the complex integer power block: types, constants and state codes.
`timescale 1ns / 1ps

package cip_pkg;

    localparam int DATA_W    = 32;
    localparam int EXP_IN_W  = 8;
    localparam int FRAC_BITS = 16;
    localparam int EXP_BITS  = 8;

    typedef struct packed {
        logic signed [DATA_W-1:0]   base_re;
        logic signed [DATA_W-1:0]   base_im;
        logic signed [EXP_IN_W-1:0] exponent;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] power_re;
        logic signed [DATA_W-1:0] power_im;
        logic                     overflow;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_PR_MUL,
        ST_PR_ACC,
        ST_DONE
    } cip_state_t;

    typedef enum logic {
        OP_SQUARE,
        OP_PRODUCT
    } cip_op_t;

    typedef struct packed {
        logic    load;
        logic    mul;
        cip_op_t op_sel;
        logic    wr_x;
        logic    wr_r;
        logic    shift_e;
        logic    out_load;
    } cip_cmd_t;

    typedef struct packed {
        logic e_zero;
        logic e_lsb;
    } cip_stat_t;

endpackage

[sv/cip_cmul.sv]
// Shared complex multiplier: registered partial products, then floor, shift and saturate.
`timescale 1ns / 1ps

module cip_cmul #(
    parameter int FRAC_BITS = cip_pkg::FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                mul_en,
    input  logic signed [cip_pkg::DATA_W-1:0]   a_re,
    input  logic signed [cip_pkg::DATA_W-1:0]   a_im,
    input  logic signed [cip_pkg::DATA_W-1:0]   b_re,
    input  logic signed [cip_pkg::DATA_W-1:0]   b_im,
    output logic signed [cip_pkg::DATA_W-1:0]   y_re,
    output logic signed [cip_pkg::DATA_W-1:0]   y_im,
    output logic                                sat
);
    import cip_pkg::*;

    localparam int PW = 2 * DATA_W;
    localparam int SW = PW + 1;

    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [SW-1:0] sum_re, sum_im, sh_re, sh_im;
    logic                 sat_re, sat_im;

    // Four products at once; register before the adders.
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            p_rr_reg <= a_re * b_re;
            p_ii_reg <= a_im * b_im;
            p_ri_reg <= a_re * b_im;
            p_ir_reg <= a_im * b_re;
        end
    end

    function automatic logic signed [DATA_W-1:0] sat_part(input logic signed [SW-1:0] v,
                                                          output logic hit);
        logic [SW-DATA_W:0] top;
        logic signed [DATA_W-1:0] r;
        begin
            top = v[SW-1:DATA_W-1];
            hit = !((top == '0) || (top == '1));
            if (!hit) begin
                r = v[DATA_W-1:0];
            end else if (v[SW-1]) begin
                r = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                r = {1'b0, {(DATA_W-1){1'b1}}};
            end
            return r;
        end
    endfunction

    always_comb begin
        // Exact sums, floor by arithmetic shift.
        sum_re = {p_rr_reg[PW-1], p_rr_reg} - {p_ii_reg[PW-1], p_ii_reg};
        sum_im = {p_ri_reg[PW-1], p_ri_reg} + {p_ir_reg[PW-1], p_ir_reg};
        sh_re  = sum_re >>> FRAC_BITS;
        sh_im  = sum_im >>> FRAC_BITS;
        y_re   = sat_part(sh_re, sat_re);
        y_im   = sat_part(sh_im, sat_im);
        sat    = sat_re | sat_im;
    end

endmodule

[sv/cip_datapath.sv]
// Datapath: base and result registers, exponent shifter, shared multiplier, output register.
`timescale 1ns / 1ps

module cip_datapath #(
    parameter int FRAC_BITS = cip_pkg::FRAC_BITS,
    parameter int EXP_BITS  = cip_pkg::EXP_BITS
) (
    input  logic               aclk,
    input  cip_pkg::cip_cmd_t  cmd,
    output cip_pkg::cip_stat_t stat,
    input  cip_pkg::in_beat_t  s_payload,
    output cip_pkg::out_beat_t m_payload
);
    import cip_pkg::*;

    localparam logic [DATA_W-1:0] OneQ = DATA_W'(1) << FRAC_BITS;

    logic signed [DATA_W-1:0] x_re_reg, x_im_reg, r_re_reg, r_im_reg;
    logic [EXP_BITS-1:0]      e_reg;
    logic                     ovf_reg;
    out_beat_t                out_reg;

    logic [EXP_IN_W-1:0]          e_clamp;
    logic [EXP_BITS+EXP_IN_W-1:0] e_wide;
    logic [EXP_BITS-1:0]          e_load;
    logic signed [DATA_W-1:0]     b_re, b_im, y_re, y_im;
    logic                         sat;

    // Clamp negative exponents to zero, then keep EXP_BITS bits.
    always_comb begin
        e_clamp = s_payload.exponent[EXP_IN_W-1] ? '0 : s_payload.exponent;
        e_wide  = {{EXP_BITS{1'b0}}, e_clamp};
        e_load  = e_wide[EXP_BITS-1:0];
        b_re    = (cmd.op_sel == OP_PRODUCT) ? r_re_reg : x_re_reg;
        b_im    = (cmd.op_sel == OP_PRODUCT) ? r_im_reg : x_im_reg;
    end

    cip_cmul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cmul (
        .aclk   (aclk),
        .mul_en (cmd.mul),
        .a_re   (x_re_reg),
        .a_im   (x_im_reg),
        .b_re   (b_re),
        .b_im   (b_im),
        .y_re   (y_re),
        .y_im   (y_im),
        .sat    (sat)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_re_reg <= s_payload.base_re;
            x_im_reg <= s_payload.base_im;
            if (e_load[0]) begin
                r_re_reg <= s_payload.base_re;
                r_im_reg <= s_payload.base_im;
            end else begin
                r_re_reg <= OneQ;
                r_im_reg <= '0;
            end
            e_reg   <= e_load >> 1;
            ovf_reg <= 1'b0;
        end else begin
            if (cmd.wr_x) begin
                x_re_reg <= y_re;
                x_im_reg <= y_im;
            end
            if (cmd.wr_r) begin
                r_re_reg <= y_re;
                r_im_reg <= y_im;
            end
            if (cmd.wr_x || cmd.wr_r) begin
                ovf_reg <= ovf_reg | sat;
            end
            if (cmd.shift_e) begin
                e_reg <= e_reg >> 1;
            end
        end
        if (cmd.out_load) begin
            out_reg.power_re <= r_re_reg;
            out_reg.power_im <= r_im_reg;
            out_reg.overflow <= ovf_reg;
        end
    end

    assign stat.e_zero = (e_reg == '0);
    assign stat.e_lsb  = e_reg[0];
    assign m_payload   = out_reg;

endmodule

[sv/cip_ctrl.sv]
// Controller: sequences square and multiply steps and owns both handshakes.
`timescale 1ns / 1ps

module cip_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output cip_pkg::cip_cmd_t  cmd,
    input  cip_pkg::cip_stat_t stat
);
    import cip_pkg::*;

    cip_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.op_sel   = OP_SQUARE;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = stat.e_zero ? ST_DONE : ST_SQ_MUL;
            end
            ST_SQ_MUL: begin
                cmd.mul    = 1'b1;
                cmd.op_sel = OP_SQUARE;
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                cmd.wr_x = 1'b1;
                if (stat.e_lsb) begin
                    state_next = ST_PR_MUL;
                end else begin
                    cmd.shift_e = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_PR_MUL: begin
                cmd.mul    = 1'b1;
                cmd.op_sel = OP_PRODUCT;
                state_next = ST_PR_ACC;
            end
            ST_PR_ACC: begin
                cmd.wr_r    = 1'b1;
                cmd.shift_e = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    // A write-back always uses products registered in the cycle before.
    a_wr_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_x || cmd.wr_r) |-> $past(cmd.mul))
        else $error("write-back without products");

    // An accepted beat closes the input right after the accept.
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input reopened right after accept");

    // Never overwrite a result that still waits.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

    // At most one of load, multiply, write-back and output load per cycle.
    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.mul, cmd.wr_x, cmd.wr_r, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule

[sv/complex_integer_power.sv]
// Top level of the complex integer power block: controller plus datapath.
`timescale 1ns / 1ps

// Raises a complex Q(31-FRAC_BITS).FRAC_BITS base to a non-negative integer power by
// square-and-multiply. A negative exponent counts as zero and gives 1+0i; only the low
// EXP_BITS bits of the exponent are used. Every square and product is rounded toward
// negative infinity and saturated to 32 bits per part; any saturation sets overflow.
// One item is worked at a time on a single shared complex multiplier (four 32x32
// products registered, then add, shift and saturate in the next cycle). The result sits
// in an output register, so a new beat is taken while the last result still waits for
// m_ready.
module complex_integer_power #(
    parameter int FRAC_BITS = cip_pkg::FRAC_BITS,
    parameter int EXP_BITS  = cip_pkg::EXP_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cip_pkg::in_beat_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output cip_pkg::out_beat_t m_payload
);
    import cip_pkg::*;

    cip_cmd_t  cmd;
    cip_stat_t stat;

    // Sequence the steps; handshakes live here.
    cip_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Hold operands, run the multiplier, hold the finished result.
    cip_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .EXP_BITS  (EXP_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .cmd       (cmd),
        .stat      (stat),
        .s_payload (s_payload),
        .m_payload (m_payload)
    );

endmodule

[bench/cip_power_checker.sv]
// Checker for the complex integer power block: predicts each result and compares it.
`timescale 1ns / 1ps

module cip_power_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  cip_pkg::in_beat_t  s_payload,
    input  logic               m_valid,
    input  logic               m_ready,
    input  cip_pkg::out_beat_t m_payload,
    output int                 fail_count,
    output int                 expected_count
);
    import cip_pkg::*;

    localparam logic signed [65:0] PART_MAX = 66'sd2147483647;
    localparam logic signed [65:0] PART_MIN = -66'sd2147483648;

    typedef struct {
        in_beat_t  src;
        out_beat_t want;
    } power_entry_t;

    power_entry_t power_q[$];
    int           mismatches = 0;

    assign fail_count = mismatches;

    // Floor of (a + b) / 2^FRAC_BITS, saturated to 32 bits; bit 32 flags saturation.
    function automatic logic [32:0] round_sat_part(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [65:0] total;
        logic signed [65:0] scaled;
        total  = a + b;
        scaled = total >>> FRAC_BITS;
        if (scaled > PART_MAX) begin
            return {1'b1, 32'sh7FFF_FFFF};
        end
        if (scaled < PART_MIN) begin
            return {1'b1, 32'sh8000_0000};
        end
        return {1'b0, scaled[31:0]};
    endfunction

    function automatic out_beat_t predict_power(input in_beat_t b);
        logic signed [31:0] xr, xi, rr, ri, sr, si, nr, ni;
        logic signed [63:0] p1, p2, p3;
        logic [32:0]        part;
        int unsigned        e;
        logic               ovf;
        out_beat_t          res;
        xr  = b.base_re;
        xi  = b.base_im;
        e   = b.exponent[EXP_IN_W-1] ? 0 : 32'(b.exponent[EXP_IN_W-2:0]);
        e   = e & ((1 << EXP_BITS) - 1);
        ovf = 1'b0;
        if (e[0]) begin
            rr = xr;
            ri = xi;
        end else begin
            rr = 32'sd1 <<< FRAC_BITS;
            ri = 32'sd0;
        end
        for (int i = 1; i < EXP_BITS; i++) begin
            e = e >> 1;
            if (e == 0) break;
            p1   = xr * xr;
            p2   = xi * xi;
            p3   = xr * xi;
            part = round_sat_part(p1, -p2);
            ovf  = ovf | part[32];
            sr   = part[31:0];
            part = round_sat_part(p3, p3);
            ovf  = ovf | part[32];
            si   = part[31:0];
            xr   = sr;
            xi   = si;
            if (e[0]) begin
                p1   = xr * rr;
                p2   = xi * ri;
                part = round_sat_part(p1, -p2);
                ovf  = ovf | part[32];
                nr   = part[31:0];
                p1   = ri * xr;
                p2   = xi * rr;
                part = round_sat_part(p1, p2);
                ovf  = ovf | part[32];
                ni   = part[31:0];
                rr   = nr;
                ri   = ni;
            end
        end
        res.power_re = rr;
        res.power_im = ri;
        res.overflow = ovf;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input in_beat_t src,
                                   input longint got, input longint want);
        $display("%0t: %s mismatch: got %0d want %0d (base %0d, %0d exp %0d)",
                 $realtime, what, got, want, src.base_re, src.base_im, src.exponent);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        power_entry_t head;
        power_entry_t fresh;
        if (!aresetn) begin
            power_q.delete();
            expected_count <= 0;
        end else begin
            // A result leaves before a new beat is queued: it can't belong to that beat.
            if (m_valid && m_ready) begin
                if (power_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_payload.power_re, 0);
                end else begin
                    head = power_q.pop_front();
                    if (m_payload.power_re !== head.want.power_re)
                        report_mismatch("power_re", head.src, m_payload.power_re,
                                        head.want.power_re);
                    if (m_payload.power_im !== head.want.power_im)
                        report_mismatch("power_im", head.src, m_payload.power_im,
                                        head.want.power_im);
                    if (m_payload.overflow !== head.want.overflow)
                        report_mismatch("overflow", head.src, m_payload.overflow,
                                        head.want.overflow);
                end
            end
            if (s_valid && s_ready) begin
                fresh.src  = s_payload;
                fresh.want = predict_power(s_payload);
                power_q.push_back(fresh);
            end
            expected_count <= power_q.size();
        end
    end

endmodule

[bench/complex_integer_power_tb.sv]
// Testbench top for the complex integer power block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module complex_integer_power_tb;
    import cip_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung. The longest
    // honest quiet stretch is the receiver hold-off below plus one item.
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT       = 600;
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_ITEMS  = 950;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_beat_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_beat_t m_payload;

    int fail_count;
    int expected_count;
    int idle_cycles = 0;

    // Longest gap each side may draw before its next beat; zero gives back-to-back runs.
    int src_max_gap = 4;
    int snk_max_gap = 4;

    always #5 aclk = ~aclk;

    complex_integer_power DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    cip_power_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .fail_count     (fail_count),
        .expected_count (expected_count)
    );

    function automatic in_beat_t mk_beat(input logic signed [31:0] re,
                                         input logic signed [31:0] im,
                                         input logic signed [7:0] e);
        in_beat_t b;
        b.base_re  = re;
        b.base_im  = im;
        b.exponent = e;
        return b;
    endfunction

    // Mix full-range parts with values near the unit circle, so that long exponents
    // still produce results that neither saturate nor decay straight to zero.
    function automatic logic signed [31:0] pick_part();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: begin
                return $urandom;
            end
            3, 4, 5, 6: begin
                return int'($urandom_range(0, 262143)) - 131072;
            end
            7: begin
                return 65536 + int'($urandom_range(0, 8191)) - 4096;
            end
            8: begin
                case ($urandom_range(0, 4))
                    0: return 32'sd0;
                    1: return 32'sh0001_0000;
                    2: return -32'sd65536;
                    3: return 32'sh7FFF_FFFF;
                    default: return 32'sh8000_0000;
                endcase
            end
            default: begin
                return int'($urandom_range(0, 15)) - 8;
            end
        endcase
    endfunction

    // Mostly non-negative exponents, which reach the square-and-multiply loop.
    function automatic logic signed [7:0] pick_exponent();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3, 4, 5: return 8'($urandom_range(0, 127));
            6:                return 8'($urandom_range(128, 255));
            7:                return 8'($urandom_range(0, 8));
            8:                return 8'(1 << $urandom_range(0, 6));
            default:          return 8'($urandom);
        endcase
    endfunction

    // Idle for a drawn gap, then hold the beat on the channel until it is taken.
    task automatic send_beat(input in_beat_t beat);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Result side: draw a gap per beat, and once drop ready for a long stretch so the
    // output register fills and the block stalls its input while the sender keeps offering.
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken == HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = $urandom_range(0, snk_max_gap);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("complex_integer_power_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats: zero and unit exponents, full-range parts, negative exponents.
        send_beat(mk_beat(32'sd0, 32'sd0, 8'sd0));
        send_beat(mk_beat(32'sh0001_0000, 32'sd0, 8'sd1));
        // Exponent one with extreme parts: no squaring happens, so no overflow.
        send_beat(mk_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'sd1));
        send_beat(mk_beat(32'sh8000_0000, 32'sh8000_0000, 8'sd2));
        send_beat(mk_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'sd2));
        send_beat(mk_beat(32'sd0, 32'sh0001_0000, 8'sd2));
        send_beat(mk_beat(32'sh0001_0000, 32'sh0001_0000, 8'sd3));
        send_beat(mk_beat(-32'sd65536, 32'sd0, 8'sd127));
        send_beat(mk_beat(32'sd32768, 32'sd32768, 8'sd127));
        // Negative exponents clamp to zero and give one with a clear flag.
        send_beat(mk_beat(32'sh7FFF_FFFF, 32'sh8000_0000, -8'sd1));
        send_beat(mk_beat(32'sh8000_0000, 32'sh7FFF_FFFF, -8'sd128));
        send_beat(mk_beat(32'sd0, 32'sd0, -8'sd50));
        // Tiny parts: rounding toward negative infinity shows in the low bits.
        send_beat(mk_beat(32'sd1, -32'sd1, 8'sd2));
        send_beat(mk_beat(32'sd0, -32'sd1, 8'sd2));
        send_beat(mk_beat(-32'sd1, 32'sd0, 8'sd64));
        send_beat(mk_beat(-32'sd1, -32'sd1, 8'sd127));
        send_beat(mk_beat(32'sh0001_0000, 32'sd0, 8'sd64));
        send_beat(mk_beat(32'sd98304, -32'sd45875, 8'sd5));
        // Most negative real part squared overflows the real part alone.
        send_beat(mk_beat(32'sh8000_0000, 32'sd0, 8'sd2));
        send_beat(mk_beat(32'sh8000_0000, 32'sd0, 8'sd1));
        send_beat(mk_beat(32'sd3, 32'sd5, 8'sd126));
        send_beat(mk_beat(-32'sd131072, 32'sd65536, 8'sd6));
        send_beat(mk_beat(32'sd65535, 32'sd1, 8'sd100));

        // Random beats: gapped, then a back-to-back stretch on both sides, then gapped.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) begin
                src_max_gap = 0;
                snk_max_gap = 0;
            end else if (n == 450) begin
                src_max_gap = 4;
                snk_max_gap = 4;
            end
            send_beat(mk_beat(pick_part(), pick_part(), pick_exponent()));
        end
        s_valid <= 1'b0;

        // Let the last beat land in the checker, then drain and wait out the latency.
        @(posedge aclk);
        while (expected_count != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_count == 0) begin
            $display("complex_integer_power_tb passed");
        end else begin
            $display("complex_integer_power_tb failed");
        end
        $finish;
    end

endmodule

[files.f]
sv/cip_pkg.sv
sv/cip_cmul.sv
sv/cip_datapath.sv
sv/cip_ctrl.sv
sv/complex_integer_power.sv
bench/cip_power_checker.sv
bench/complex_integer_power_tb.sv
